/* design/mst_pkg.sv */
`default_nettype none
package mst_pkg;

  localparam int MAX_TOKEN = 32;
  localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
  localparam int IDX_W     = $clog2(MAX_TOKEN);

  localparam logic [19:0] LINE_TOP = 20'hFFFFF;
  localparam logic [30:0] SIZE_TOP = 31'h7FFFFFFF;

  typedef enum logic [2:0] {
    TK_PREPROC = 3'd0,
    TK_TYPE    = 3'd1,
    TK_MATRIX  = 3'd2,
    TK_IDENT   = 3'd3,
    TK_NUMBER  = 3'd4,
    TK_OPER    = 3'd5,
    TK_SYMBOL  = 3'd6,
    TK_END     = 3'd7
  } tok_kind_t;

  // one entry of the front-to-back queue: a single word or a buffered token
  typedef struct packed {
    logic              is_flush;
    tok_kind_t         kind;
    logic [7:0]        ch;
    logic              has;
    logic              cut;
    logic [LEN_W-1:0]  len;
    logic [19:0]       line;
    logic [30:0]       largest;
    logic              last;
  } cmd_t;

endpackage
`default_nettype wire

/* design/mst_cmdq.sv */
`default_nettype none
module mst_cmdq import mst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic rd_en,
  output logic      rd_valid,
  output cmd_t      rd_cmd,
  output logic      has_flush
);

  cmd_t ent_r [2];
  logic [1:0] v_r, v_nxt;
  logic wr_r, rd_r;

  assign full      = v_r[wr_r];
  assign rd_valid  = v_r[rd_r];
  assign rd_cmd    = ent_r[rd_r];
  assign has_flush = (v_r[0] & ent_r[0].is_flush) | (v_r[1] & ent_r[1].is_flush);

  always_comb begin
    v_nxt = v_r;
    if (rd_en && rd_valid) v_nxt[rd_r] = 1'b0;
    if (wr_en && !full) v_nxt[wr_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      wr_r <= 1'b0;
      rd_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      if (wr_en && !full) wr_r <= ~wr_r;
      if (rd_en && rd_valid) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) ent_r[wr_r] <= wr_cmd;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && full) |=> $stable(v_r))
    else $error("queue write while full changed state");

endmodule
`default_nettype wire

/* design/mst_front.sv */
`default_nettype none
module mst_front import mst_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire logic             in_kind,
  input  wire logic [7:0]       in_byte,
  input  wire logic             q_full,
  input  wire logic             flush_pend,
  output logic                  cmd_push,
  output cmd_t                  cmd,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic [7:0]            rd_data
);

  typedef enum logic [8:0] {
    M_NORMAL    = 9'b000000001,
    M_IDENT     = 9'b000000010,
    M_NUMBER    = 9'b000000100,
    M_BRACKET   = 9'b000001000,
    M_DIRECTIVE = 9'b000010000,
    M_DEF_SPACE = 9'b000100000,
    M_DEF_NAME  = 9'b001000000,
    M_DEF_SEEK  = 9'b010000000,
    M_DEF_DIGITS= 9'b100000000
  } mode_t;

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic is_upper(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction
  function automatic logic is_alpha(logic [7:0] c);
    return is_upper(c) || (c >= "a" && c <= "z");
  endfunction
  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  mode_t            mode_r, mode_nxt;
  logic [7:0]       buf_r [MAX_TOKEN];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             cut_r, cut_nxt;
  logic [19:0]      line_r, line_nxt;
  logic [30:0]      acc_r, acc_nxt;
  logic [30:0]      big_r, big_nxt;
  logic             item_v_r, item_v_nxt;
  logic             item_end_r;
  logic [7:0]       c_r;

  logic             go, wr_en;
  logic [34:0]      acc_wide;
  logic [30:0]      big_fin;
  logic             kw_type, kw_define, kw_size, normal_emits, buf_room;
  tok_kind_t        id_kind;

  assign in_full = item_v_r;
  assign rd_data = buf_r[rd_idx];
  assign go      = item_v_r && !flush_pend && !q_full;
  assign buf_room = len_r < LEN_W'(MAX_TOKEN);

  assign kw_type = !cut_r && (
      (len_r == LEN_W'(3) && buf_r[0] == "i" && buf_r[1] == "n" && buf_r[2] == "t") ||
      (len_r == LEN_W'(5) && buf_r[0] == "f" && buf_r[1] == "l" && buf_r[2] == "o" &&
       buf_r[3] == "a" && buf_r[4] == "t") ||
      (len_r == LEN_W'(6) && buf_r[0] == "d" && buf_r[1] == "o" && buf_r[2] == "u" &&
       buf_r[3] == "b" && buf_r[4] == "l" && buf_r[5] == "e") ||
      (len_r == LEN_W'(6) && buf_r[0] == "M" && buf_r[1] == "A" && buf_r[2] == "T" &&
       buf_r[3] == "R" && buf_r[4] == "I" && buf_r[5] == "X"));
  assign kw_define = !cut_r && len_r == LEN_W'(6) && buf_r[0] == "d" && buf_r[1] == "e" &&
      buf_r[2] == "f" && buf_r[3] == "i" && buf_r[4] == "n" && buf_r[5] == "e";
  assign kw_size = !cut_r && (
      (len_r == LEN_W'(1) && buf_r[0] == "N") ||
      (len_r == LEN_W'(4) && buf_r[0] == "S" && buf_r[1] == "I" && buf_r[2] == "Z" &&
       buf_r[3] == "E") ||
      (len_r == LEN_W'(4) && buf_r[0] == "R" && buf_r[1] == "O" && buf_r[2] == "W" &&
       buf_r[3] == "S") ||
      (len_r == LEN_W'(4) && buf_r[0] == "C" && buf_r[1] == "O" && buf_r[2] == "L" &&
       buf_r[3] == "S") ||
      (len_r == LEN_W'(5) && buf_r[0] == "I" && buf_r[1] == "N" && buf_r[2] == "N" &&
       buf_r[3] == "E" && buf_r[4] == "R"));

  always_comb begin
    if (kw_type) id_kind = TK_TYPE;
    else if (!cut_r && len_r == LEN_W'(1) && is_upper(buf_r[0])) id_kind = TK_MATRIX;
    else id_kind = TK_IDENT;
  end

  // after a flush the byte falls into normal scanning; does that give a word?
  assign normal_emits = !(is_space(c_r) || is_alpha(c_r) || c_r == "_" ||
                          is_digit(c_r) || c_r == "[");

  assign acc_wide = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + 35'(c_r - "0");
  assign big_fin  = (acc_r > big_r) ? acc_r : big_r;

  always_comb begin
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    cut_nxt    = cut_r;
    line_nxt   = line_r;
    acc_nxt    = acc_r;
    big_nxt    = big_r;
    item_v_nxt = item_v_r;
    wr_en      = 1'b0;
    cmd_push   = 1'b0;
    cmd          = '0;
    cmd.kind     = TK_SYMBOL;
    cmd.ch       = c_r;
    cmd.has      = 1'b1;
    cmd.len      = len_r;
    cmd.cut      = cut_r;
    cmd.line     = line_r;
    cmd.largest  = big_r;
    cmd.last     = 1'b1;

    if (!item_v_r) begin
      if (in_push) item_v_nxt = 1'b1;
    end else if (go) begin
      item_v_nxt = 1'b0;
      if (item_end_r) begin
        if (mode_r == M_IDENT || mode_r == M_NUMBER) begin
          cmd_push     = 1'b1;
          cmd.is_flush = 1'b1;
          cmd.kind     = (mode_r == M_IDENT) ? id_kind : TK_NUMBER;
          cmd.last     = 1'b0;
          mode_nxt     = M_NORMAL;
          item_v_nxt   = 1'b1;
        end else begin
          cmd_push    = 1'b1;
          cmd.kind    = TK_END;
          cmd.ch      = 8'd0;
          cmd.has     = 1'b0;
          cmd.cut     = 1'b0;
          cmd.largest = (mode_r == M_DEF_DIGITS) ? big_fin : big_r;
          mode_nxt    = M_NORMAL;
          len_nxt     = '0;
          cut_nxt     = 1'b0;
          line_nxt    = 20'd1;
          acc_nxt     = '0;
          big_nxt     = '0;
        end
      end else begin
        case (mode_r)
          M_IDENT, M_NUMBER: begin
            if (mode_r == M_IDENT ? is_word(c_r) : is_digit(c_r)) begin
              if (buf_room) begin wr_en = 1'b1; len_nxt = len_r + 1'b1; end
              else cut_nxt = 1'b1;
            end else begin
              cmd_push     = 1'b1;
              cmd.is_flush = 1'b1;
              cmd.kind     = (mode_r == M_IDENT) ? id_kind : TK_NUMBER;
              cmd.last     = !normal_emits;
              mode_nxt     = M_NORMAL;
              item_v_nxt   = 1'b1;
            end
          end
          M_BRACKET: begin
            if (c_r == "]") mode_nxt = M_NORMAL;
          end
          M_DIRECTIVE: begin
            if (is_alpha(c_r)) begin
              if (buf_room) begin wr_en = 1'b1; len_nxt = len_r + 1'b1; end
              else cut_nxt = 1'b1;
            end else begin
              mode_nxt   = kw_define ? M_DEF_SPACE : M_NORMAL;
              len_nxt    = '0;
              cut_nxt    = 1'b0;
              item_v_nxt = 1'b1;
            end
          end
          M_DEF_SPACE: begin
            if (!is_space(c_r)) begin
              mode_nxt   = M_DEF_NAME;
              len_nxt    = '0;
              cut_nxt    = 1'b0;
              item_v_nxt = 1'b1;
            end
          end
          M_DEF_NAME: begin
            if (is_word(c_r)) begin
              if (buf_room) begin wr_en = 1'b1; len_nxt = len_r + 1'b1; end
              else cut_nxt = 1'b1;
            end else begin
              mode_nxt   = kw_size ? M_DEF_SEEK : M_NORMAL;
              len_nxt    = '0;
              cut_nxt    = 1'b0;
              item_v_nxt = 1'b1;
            end
          end
          M_DEF_SEEK: begin
            if (is_digit(c_r)) begin
              mode_nxt   = M_DEF_DIGITS;
              acc_nxt    = '0;
              item_v_nxt = 1'b1;
            end
          end
          M_DEF_DIGITS: begin
            if (is_digit(c_r)) begin
              acc_nxt = (acc_wide > 35'(SIZE_TOP)) ? SIZE_TOP : acc_wide[30:0];
            end else begin
              big_nxt    = big_fin;
              acc_nxt    = '0;
              mode_nxt   = M_NORMAL;
              item_v_nxt = 1'b1;
            end
          end
          default: begin
            mode_nxt = M_NORMAL;
            if (c_r == "#") begin
              cmd_push = 1'b1;
              cmd.kind = TK_PREPROC;
              cmd.cut  = 1'b0;
              mode_nxt = M_DIRECTIVE;
              len_nxt  = '0;
              cut_nxt  = 1'b0;
            end else if (is_space(c_r)) begin
              if (c_r == 8'h0A && line_r < LINE_TOP) line_nxt = line_r + 1'b1;
            end else if (is_alpha(c_r) || c_r == "_" || is_digit(c_r)) begin
              mode_nxt = is_digit(c_r) ? M_NUMBER : M_IDENT;
              wr_en    = 1'b1;
              len_nxt  = LEN_W'(1);
              cut_nxt  = 1'b0;
            end else if (c_r == "[") begin
              mode_nxt = M_BRACKET;
            end else begin
              cmd_push = 1'b1;
              cmd.cut  = 1'b0;
              cmd.kind = (c_r == "+" || c_r == "-" || c_r == "*" || c_r == "/" ||
                          c_r == "=") ? TK_OPER : TK_SYMBOL;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_NORMAL;
      len_r    <= '0;
      cut_r    <= 1'b0;
      line_r   <= 20'd1;
      acc_r    <= '0;
      big_r    <= '0;
      item_v_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      len_r    <= len_nxt;
      cut_r    <= cut_nxt;
      line_r   <= line_nxt;
      acc_r    <= acc_nxt;
      big_r    <= big_nxt;
      item_v_r <= item_v_nxt;
    end
  end

  // a new token starts at slot 0; extensions write at the current length
  always_ff @(posedge clk) begin
    if (in_push && !item_v_r) begin
      item_end_r <= in_kind;
      c_r        <= in_byte;
    end
    if (wr_en) begin
      if (mode_r == M_NORMAL) buf_r[0] <= c_r;
      else buf_r[len_r[IDX_W-1:0]] <= c_r;
    end
  end

  a_no_write_under_flush: assert property (@(posedge clk) disable iff (!rst_n)
    flush_pend |-> !wr_en)
    else $error("token buffer written while a flush is being read");

  a_flush_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_push && cmd.is_flush) |-> (cmd.len != '0 && cmd.len <= LEN_W'(MAX_TOKEN)))
    else $error("flush with bad length");

endmodule
`default_nettype wire

/* design/mst_back.sv */
`default_nettype none
module mst_back import mst_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  output logic                   active,
  output logic [IDX_W-1:0]       rd_idx,
  input  wire logic [7:0]        rd_data,
  output logic                   empty,
  input  wire logic              pop,
  output logic [2:0]             out_token_kind,
  output logic [19:0]            out_line_number,
  output logic [7:0]             out_token_char,
  output logic                   out_has_char,
  output logic                   out_token_end,
  output logic                   out_run_last,
  output logic                   out_truncated,
  output logic [30:0]            out_largest_size
);

  cmd_t             cur_r;
  logic             active_r;
  logic [LEN_W-1:0] idx_r;
  logic             out_v_r;
  logic             adv, at_end;

  assign adv    = !out_v_r || pop;
  assign q_pop  = !active_r && q_valid && adv;
  assign active = active_r;
  assign rd_idx = idx_r[IDX_W-1:0];
  assign at_end = (idx_r + 1'b1) == cur_r.len;
  assign empty  = !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (active_r && adv) begin
        out_v_r <= 1'b1;
        if (at_end) active_r <= 1'b0;
      end else if (q_pop) begin
        if (q_cmd.is_flush) begin
          active_r <= q_cmd.len != '0;
          out_v_r  <= 1'b0;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active_r && adv) begin
      out_token_kind   <= cur_r.kind;
      out_line_number  <= cur_r.line;
      out_token_char   <= rd_data;
      out_has_char     <= 1'b1;
      out_token_end    <= at_end;
      out_run_last     <= at_end && cur_r.last;
      out_truncated    <= cur_r.cut;
      out_largest_size <= cur_r.largest;
      idx_r            <= idx_r + 1'b1;
    end else if (q_pop) begin
      cur_r <= q_cmd;
      idx_r <= '0;
      if (!q_cmd.is_flush) begin
        out_token_kind   <= q_cmd.kind;
        out_line_number  <= q_cmd.line;
        out_token_char   <= q_cmd.ch;
        out_has_char     <= q_cmd.has;
        out_token_end    <= 1'b1;
        out_run_last     <= q_cmd.last;
        out_truncated    <= q_cmd.cut;
        out_largest_size <= q_cmd.largest;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> idx_r < cur_r.len)
    else $error("flush index past token length");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !pop) |=> (out_v_r && $stable(out_token_char) && $stable(out_run_last)))
    else $error("waiting word changed under stall");

endmodule
`default_nettype wire

/* design/matrix_source_tokenizer.sv */
`default_nettype none
// channel | ports                                   | handshake
// input   | in_kind, in_source_byte                 | push / full
// result  | out_token_kind .. out_largest_size      | empty / pop
//
// A byte is accepted, then scanned, and scanned again when it ends a token or
// a field; a scan waits while a flush is pending or the queue is full.
// A finished token is handed over through the queue, then replayed one word per cycle while the output is popped.
// Reset is synchronous active low and returns all scan state to line one.
// A byte is not scanned while a finished token is still being read out, and full stays high until it is.
module matrix_source_tokenizer import mst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_source_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_token_kind,
  output logic [19:0]      out_line_number,
  output logic [7:0]       out_token_char,
  output logic             out_has_char,
  output logic             out_token_end,
  output logic             out_run_last,
  output logic             out_truncated,
  output logic [30:0]      out_largest_size
);

  cmd_t             f_cmd, q_cmd;
  logic             f_push, q_full, q_valid, q_pop, q_has_flush, b_active;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_data;

  mst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (push),
    .in_full    (full),
    .in_kind    (in_kind),
    .in_byte    (in_source_byte),
    .q_full     (q_full),
    .flush_pend (q_has_flush | b_active),
    .cmd_push   (f_push),
    .cmd        (f_cmd),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data)
  );

  mst_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (f_push),
    .wr_cmd    (f_cmd),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_valid  (q_valid),
    .rd_cmd    (q_cmd),
    .has_flush (q_has_flush)
  );

  mst_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .active           (b_active),
    .rd_idx           (rd_idx),
    .rd_data          (rd_data),
    .empty            (empty),
    .pop              (pop),
    .out_token_kind   (out_token_kind),
    .out_line_number  (out_line_number),
    .out_token_char   (out_token_char),
    .out_has_char     (out_has_char),
    .out_token_end    (out_token_end),
    .out_run_last     (out_run_last),
    .out_truncated    (out_truncated),
    .out_largest_size (out_largest_size)
  );

endmodule
`default_nettype wire
